FILE: design/lc3p_pkg.sv
package lc3p_pkg;

	localparam int TRAP_DEPTH   = 32;
	localparam int MEMORY_WORDS = 65536;
	localparam int MEM_AW       = $clog2(MEMORY_WORDS);
	localparam int TL_W         = $clog2(TRAP_DEPTH + 1);
	localparam int TI_W         = (TRAP_DEPTH > 1) ? $clog2(TRAP_DEPTH) : 1;

	// device and vector addresses
	localparam logic [15:0] A_KBSR   = 16'hFE00;
	localparam logic [15:0] A_KBDR   = 16'hFE02;
	localparam logic [15:0] A_DSR    = 16'hFE04;
	localparam logic [15:0] A_DDR    = 16'hFE06;
	localparam logic [15:0] A_TR     = 16'hFE08;
	localparam logic [15:0] A_TMI    = 16'hFE0A;
	localparam logic [15:0] A_MPR    = 16'hFE12;
	localparam logic [15:0] A_MCR    = 16'hFFFE;
	localparam logic [15:0] VEC_BASE = 16'h0100;

	localparam logic [15:0] PC_RESET  = 16'h0200;
	localparam logic [15:0] PSR_RESET = 16'h8002;
	localparam logic [15:0] SSP_RESET = 16'hFDFF;
	localparam logic [15:0] USP_RESET = 16'hBFFF;
	localparam logic [15:0] MCR_RESET = 16'h8000;
	localparam logic [15:0] DEV_READY = 16'h8000;

	// item kinds
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_EXEC = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	// stop reasons
	localparam logic [1:0] STOP_NONE = 2'd0;
	localparam logic [1:0] STOP_RSV  = 2'd1;
	localparam logic [1:0] STOP_JMP  = 2'd2;
	localparam logic [1:0] STOP_TRAP = 2'd3;

	// opcodes
	localparam logic [3:0] OPC_BR   = 4'd0;
	localparam logic [3:0] OPC_ADD  = 4'd1;
	localparam logic [3:0] OPC_LD   = 4'd2;
	localparam logic [3:0] OPC_ST   = 4'd3;
	localparam logic [3:0] OPC_JSR  = 4'd4;
	localparam logic [3:0] OPC_AND  = 4'd5;
	localparam logic [3:0] OPC_LDR  = 4'd6;
	localparam logic [3:0] OPC_STR  = 4'd7;
	localparam logic [3:0] OPC_RTI  = 4'd8;
	localparam logic [3:0] OPC_NOT  = 4'd9;
	localparam logic [3:0] OPC_LDI  = 4'd10;
	localparam logic [3:0] OPC_STI  = 4'd11;
	localparam logic [3:0] OPC_JMP  = 4'd12;
	localparam logic [3:0] OPC_RSV  = 4'd13;
	localparam logic [3:0] OPC_LEA  = 4'd14;
	localparam logic [3:0] OPC_TRAP = 4'd15;

	// datapath micro-operations
	localparam int UOP_W = 5;
	localparam logic [UOP_W-1:0] U_NOP      = 5'd0;
	localparam logic [UOP_W-1:0] U_ACCEPT   = 5'd1;
	localparam logic [UOP_W-1:0] U_CLR      = 5'd2;
	localparam logic [UOP_W-1:0] U_LOAD     = 5'd3;
	localparam logic [UOP_W-1:0] U_PEEK_RD  = 5'd4;
	localparam logic [UOP_W-1:0] U_PEEK_CAP = 5'd5;
	localparam logic [UOP_W-1:0] U_FETCH    = 5'd6;
	localparam logic [UOP_W-1:0] U_M_KB1    = 5'd7;
	localparam logic [UOP_W-1:0] U_M_KB2    = 5'd8;
	localparam logic [UOP_W-1:0] U_M_KB0    = 5'd9;
	localparam logic [UOP_W-1:0] U_M_DSR    = 5'd10;
	localparam logic [UOP_W-1:0] U_M_RD     = 5'd11;
	localparam logic [UOP_W-1:0] U_M_CAP    = 5'd12;
	localparam logic [UOP_W-1:0] U_DECODE   = 5'd13;
	localparam logic [UOP_W-1:0] U_EXEC     = 5'd14;
	localparam logic [UOP_W-1:0] U_LD_FIN   = 5'd15;
	localparam logic [UOP_W-1:0] U_IND      = 5'd16;
	localparam logic [UOP_W-1:0] U_W_TMI    = 5'd17;
	localparam logic [UOP_W-1:0] U_W_WR     = 5'd18;
	localparam logic [UOP_W-1:0] U_TRAP_FIN = 5'd19;
	localparam logic [UOP_W-1:0] U_RTI1     = 5'd20;
	localparam logic [UOP_W-1:0] U_RTI2     = 5'd21;
	localparam logic [UOP_W-1:0] U_RTI3     = 5'd22;
	localparam logic [UOP_W-1:0] U_FAULT    = 5'd23;
	localparam logic [UOP_W-1:0] U_T_TICK   = 5'd24;
	localparam logic [UOP_W-1:0] U_V1       = 5'd25;
	localparam logic [UOP_W-1:0] U_V2       = 5'd26;
	localparam logic [UOP_W-1:0] U_V3       = 5'd27;
	localparam logic [UOP_W-1:0] U_V4       = 5'd28;
	localparam logic [UOP_W-1:0] U_DONE     = 5'd29;

	typedef struct packed {
		logic [UOP_W-1:0] uop;
	} cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic       acc_fault;
		logic       is_kbsr;
		logic       is_dsr;
		logic       is_tmi;
		logic       key_avail;
		logic [3:0] opcode;
		logic       jmp_bad;
		logic       trap_full;
		logic       user;
		logic       timer_go;
		logic       timer_fire;
		logic       running;
		logic       out_free;
	} dp_stat_t;

	function automatic logic [2:0] cc_of(input logic [15:0] v);
		if (v == 16'h0000)
			return 3'b010;
		else if (v[15])
			return 3'b100;
		else
			return 3'b001;
	endfunction

endpackage

FILE: design/lc3_core_with_protection_and_timer_unit.sv
// LC-3 style processor with user/supervisor protection, a bounded trap return
// stack and a user-mode interval timer, driven one item at a time: an item
// loads a memory word, peeks a memory word, or executes one instruction, and
// every item returns exactly one result. After reset the 64K-word main memory
// is swept clear (machine control at 0xFFFE set to 0x8000), and no item is
// taken during the sweep. The single-port synchronous memory sets the pace: a
// load is one write, a peek a read and a capture, and an instruction steps
// through fetch, up to two checked reads or a read and a write, keyboard side
// effects, timer update, and a two-word exception frame push plus vector read
// when a fault or timer interrupt is taken. The next item is accepted while the
// previous result still waits in the output register.
module lc3_core_with_protection_and_timer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // address[15:0] data[31:16] key_ready[32] key_code[40:33]
	input  logic [1:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // pc[15:0] status_word[31:16] read_data[47:32]
	                               // display_valid[48] display_char[56:49] key_taken[57]
	                               // fault_taken[58] timer_irq_taken[59] running[60]
	                               // stop_reason[62:61]
);
	import lc3p_pkg::*;

	cmd_t     cmd;
	dp_stat_t st;

	// sequencer: one microstep per cycle, except while it waits for an item or for the output register to free
	lc3p_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_op     (s_tuser),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// registers, memory, device shadows and result register
	lc3p_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.s_tdata  (s_tdata),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);
endmodule

FILE: design/lc3p_ram.sv
module lc3p_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

FILE: design/lc3p_ctrl.sv
module lc3p_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic [1:0]        s_op,
	output logic              s_tready,
	input  lc3p_pkg::dp_stat_t st,
	output lc3p_pkg::cmd_t     cmd
);
	import lc3p_pkg::*;

	localparam logic [4:0] ST_CLR     = 5'd0;
	localparam logic [4:0] ST_IDLE    = 5'd1;
	localparam logic [4:0] ST_LOAD    = 5'd2;
	localparam logic [4:0] ST_PEEK    = 5'd3;
	localparam logic [4:0] ST_PEEK2   = 5'd4;
	localparam logic [4:0] ST_FETCH   = 5'd5;
	localparam logic [4:0] ST_MCHK    = 5'd6;
	localparam logic [4:0] ST_MKB2    = 5'd7;
	localparam logic [4:0] ST_MCAP    = 5'd8;
	localparam logic [4:0] ST_DECODE  = 5'd9;
	localparam logic [4:0] ST_EXEC    = 5'd10;
	localparam logic [4:0] ST_FAULT   = 5'd11;
	localparam logic [4:0] ST_LD2     = 5'd12;
	localparam logic [4:0] ST_LDFIN   = 5'd13;
	localparam logic [4:0] ST_STI2    = 5'd14;
	localparam logic [4:0] ST_WCHK    = 5'd15;
	localparam logic [4:0] ST_WWR     = 5'd16;
	localparam logic [4:0] ST_TRAPFIN = 5'd17;
	localparam logic [4:0] ST_RTI1    = 5'd18;
	localparam logic [4:0] ST_RTI2    = 5'd19;
	localparam logic [4:0] ST_RTI3    = 5'd20;
	localparam logic [4:0] ST_TIMER   = 5'd21;
	localparam logic [4:0] ST_V1      = 5'd22;
	localparam logic [4:0] ST_V2      = 5'd23;
	localparam logic [4:0] ST_V3      = 5'd24;
	localparam logic [4:0] ST_V4      = 5'd25;
	localparam logic [4:0] ST_DONE    = 5'd26;

	// where a memory read returns to
	localparam logic [2:0] R_FETCH = 3'd0;
	localparam logic [2:0] R_LD    = 3'd1;
	localparam logic [2:0] R_LD3   = 3'd2;
	localparam logic [2:0] R_STI   = 3'd3;
	localparam logic [2:0] R_TRAP  = 3'd4;

	logic [4:0] state_q, state_d;
	logic [2:0] ret_q, ret_d;
	logic [4:0] ret_state;

	always_comb begin
		unique case (ret_q)
			R_FETCH: ret_state = ST_DECODE;
			R_LD:    ret_state = ST_LD2;
			R_LD3:   ret_state = ST_LDFIN;
			R_STI:   ret_state = ST_STI2;
			R_TRAP:  ret_state = ST_TRAPFIN;
			default: ret_state = ST_DONE;
		endcase
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd.uop = U_NOP;
		unique case (state_q)
			ST_CLR: begin
				cmd.uop = U_CLR;
				if (st.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.uop = U_ACCEPT;
					if (s_op == OP_LOAD)
						state_d = ST_LOAD;
					else if (s_op == OP_PEEK)
						state_d = ST_PEEK;
					else if (s_op == OP_EXEC && st.running)
						state_d = ST_FETCH;
					else
						state_d = ST_DONE;
				end
			end
			ST_LOAD: begin
				cmd.uop = U_LOAD;
				state_d = ST_DONE;
			end
			ST_PEEK: begin
				cmd.uop = U_PEEK_RD;
				state_d = ST_PEEK2;
			end
			ST_PEEK2: begin
				cmd.uop = U_PEEK_CAP;
				state_d = ST_DONE;
			end
			ST_FETCH: begin
				cmd.uop = U_FETCH;
				ret_d   = R_FETCH;
				state_d = ST_MCHK;
			end
			ST_MCHK: begin
				if (st.acc_fault) begin
					cmd.uop = U_FAULT;
					state_d = ST_V1;
				end else if (st.is_kbsr && st.key_avail) begin
					cmd.uop = U_M_KB1;
					state_d = ST_MKB2;
				end else if (st.is_kbsr) begin
					cmd.uop = U_M_KB0;
					state_d = ret_state;
				end else if (st.is_dsr) begin
					cmd.uop = U_M_DSR;
					state_d = ret_state;
				end else begin
					cmd.uop = U_M_RD;
					state_d = ST_MCAP;
				end
			end
			ST_MKB2: begin
				cmd.uop = U_M_KB2;
				state_d = ret_state;
			end
			ST_MCAP: begin
				cmd.uop = U_M_CAP;
				state_d = ret_state;
			end
			ST_DECODE: begin
				cmd.uop = U_DECODE;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.uop = U_EXEC;
				unique case (st.opcode)
					OPC_LD, OPC_LDI, OPC_LDR: begin
						ret_d   = R_LD;
						state_d = ST_MCHK;
					end
					OPC_ST, OPC_STR: state_d = ST_WCHK;
					OPC_STI: begin
						ret_d   = R_STI;
						state_d = ST_MCHK;
					end
					OPC_JMP: state_d = st.jmp_bad ? ST_DONE : ST_TIMER;
					OPC_TRAP: begin
						if (st.trap_full) begin
							state_d = ST_DONE;
						end else begin
							ret_d   = R_TRAP;
							state_d = ST_MCHK;
						end
					end
					OPC_RTI: state_d = st.user ? ST_FAULT : ST_RTI1;
					OPC_RSV: state_d = ST_DONE;
					default: state_d = ST_TIMER;
				endcase
			end
			ST_FAULT: begin
				cmd.uop = U_FAULT;
				state_d = ST_V1;
			end
			ST_LD2: begin
				if (st.opcode == OPC_LDI) begin
					cmd.uop = U_IND;
					ret_d   = R_LD3;
					state_d = ST_MCHK;
				end else begin
					cmd.uop = U_LD_FIN;
					state_d = ST_TIMER;
				end
			end
			ST_LDFIN: begin
				cmd.uop = U_LD_FIN;
				state_d = ST_TIMER;
			end
			ST_STI2: begin
				cmd.uop = U_IND;
				state_d = ST_WCHK;
			end
			ST_WCHK: begin
				if (st.acc_fault) begin
					cmd.uop = U_FAULT;
					state_d = ST_V1;
				end else if (st.is_tmi) begin
					cmd.uop = U_W_TMI;
					state_d = ST_WWR;
				end else begin
					cmd.uop = U_W_WR;
					state_d = ST_TIMER;
				end
			end
			ST_WWR: begin
				cmd.uop = U_W_WR;
				state_d = ST_TIMER;
			end
			ST_TRAPFIN: begin
				cmd.uop = U_TRAP_FIN;
				state_d = ST_TIMER;
			end
			ST_RTI1: begin
				cmd.uop = U_RTI1;
				state_d = ST_RTI2;
			end
			ST_RTI2: begin
				cmd.uop = U_RTI2;
				state_d = ST_RTI3;
			end
			ST_RTI3: begin
				cmd.uop = U_RTI3;
				state_d = ST_TIMER;
			end
			ST_TIMER: begin
				if (st.timer_go) begin
					cmd.uop = U_T_TICK;
					state_d = st.timer_fire ? ST_V1 : ST_DONE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_V1: begin
				cmd.uop = U_V1;
				state_d = ST_V2;
			end
			ST_V2: begin
				cmd.uop = U_V2;
				state_d = ST_V3;
			end
			ST_V3: begin
				cmd.uop = U_V3;
				state_d = ST_V4;
			end
			ST_V4: begin
				cmd.uop = U_V4;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.uop = U_DONE;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			ret_q   <= R_FETCH;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end
endmodule

FILE: design/lc3p_dp.sv
module lc3p_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  lc3p_pkg::cmd_t     cmd,
	output lc3p_pkg::dp_stat_t st,
	input  logic [47:0]       s_tdata,
	output logic [63:0]       m_tdata,
	output logic              m_tvalid,
	input  logic              m_tready
);
	import lc3p_pkg::*;

	// architectural state
	logic [15:0]     pc_q, psr_q, sss_q, uss_q, tc_q;
	logic [15:0]     r_q [8];
	logic [TL_W-1:0] tl_q;
	logic [1:0]      stop_q;
	logic [15:0]     mpr_q, tmi_q, mcr_q;
	logic [MEM_AW-1:0] clr_cnt_q;
	logic            out_valid_q;
	logic            tsm_q [TRAP_DEPTH];
	logic [15:0]     tra_q [TRAP_DEPTH];

	// per-item scratch
	logic [15:0] maddr_q, mdata_q, ir_q, psr0_q, t_q;
	logic [15:0] addr_in_q, data_in_q;
	logic [7:0]  key_code_q;
	logic        key_avail_q, vec_q;
	logic        exc_q, took_q, dv_q, irq_q;
	logic [7:0]  dc_q;
	logic [15:0] peek_q;
	logic [63:0] out_q;

	logic              ram_we;
	logic [MEM_AW-1:0] ram_addr;
	logic [15:0]       ram_wd, ram_rd;

	logic [3:0]  opc;
	logic [2:0]  dr, sr;
	logic [15:0] sext9, sext6, sext5, sext11, rs, rd, alu_b;
	logic [15:0] tc_inc, vbase, wdata;
	logic [TL_W-1:0] tl_m1;
	logic [TI_W-1:0] tl_idx, top_idx;
	logic        fire, ret_hit, running;

	assign opc    = ir_q[15:12];
	assign dr     = ir_q[11:9];
	assign sr     = ir_q[8:6];
	assign sext9  = {{7{ir_q[8]}}, ir_q[8:0]};
	assign sext6  = {{10{ir_q[5]}}, ir_q[5:0]};
	assign sext5  = {{11{ir_q[4]}}, ir_q[4:0]};
	assign sext11 = {{5{ir_q[10]}}, ir_q[10:0]};
	assign rs     = r_q[sr];
	assign rd     = r_q[dr];
	assign alu_b  = ir_q[5] ? sext5 : r_q[ir_q[2:0]];
	assign wdata  = rd;
	assign tc_inc = tc_q + 16'd1;
	assign fire   = (tc_inc >= tmi_q);
	assign vbase  = psr_q[15] ? r_q[6] : sss_q;
	assign tl_m1  = tl_q - TL_W'(1);
	assign tl_idx = tl_q[TI_W-1:0];
	assign top_idx = tl_m1[TI_W-1:0];
	assign ret_hit = (sr == 3'd7) && (tl_q != '0) && (r_q[7] == tra_q[top_idx]);
	assign running = mcr_q[15] && (stop_q == STOP_NONE);

	always_comb begin
		st.clr_last   = (clr_cnt_q == {MEM_AW{1'b1}});
		st.acc_fault  = !psr_q[15] && (!mpr_q[maddr_q[15:12]] || (maddr_q >= A_KBSR));
		st.is_kbsr    = (maddr_q == A_KBSR);
		st.is_dsr     = (maddr_q == A_DSR);
		st.is_tmi     = (maddr_q == A_TMI);
		st.key_avail  = key_avail_q;
		st.opcode     = opc;
		st.jmp_bad    = (ir_q[5:0] != 6'd0) && (ir_q[5:0] != 6'd1);
		st.trap_full  = (tl_q >= TL_W'(TRAP_DEPTH));
		st.user       = !psr_q[15];
		st.timer_go   = !psr0_q[15] && !psr_q[15] && (tmi_q != 16'h0000);
		st.timer_fire = fire;
		st.running    = running;
		st.out_free   = !out_valid_q || m_tready;
	end

	// memory port
	always_comb begin
		ram_we   = 1'b0;
		ram_addr = maddr_q;
		ram_wd   = 16'h0000;
		unique case (cmd.uop)
			U_CLR: begin
				ram_we   = 1'b1;
				ram_addr = clr_cnt_q;
				ram_wd   = (clr_cnt_q == A_MCR) ? MCR_RESET : 16'h0000;
			end
			U_LOAD: begin
				ram_we   = 1'b1;
				ram_addr = addr_in_q;
				ram_wd   = data_in_q;
			end
			U_PEEK_RD: ram_addr = addr_in_q;
			U_M_KB1: begin
				ram_we   = 1'b1;
				ram_addr = A_KBSR;
				ram_wd   = DEV_READY;
			end
			U_M_KB2: begin
				ram_we   = 1'b1;
				ram_addr = A_KBDR;
				ram_wd   = {8'h00, key_code_q};
			end
			U_M_KB0: begin
				ram_we   = 1'b1;
				ram_addr = A_KBSR;
			end
			U_M_DSR: begin
				ram_we   = 1'b1;
				ram_addr = A_DSR;
				ram_wd   = DEV_READY;
			end
			U_W_TMI: begin
				ram_we   = 1'b1;
				ram_addr = A_TR;
			end
			U_W_WR: begin
				ram_we   = 1'b1;
				ram_wd   = wdata;
			end
			U_T_TICK: begin
				ram_we   = 1'b1;
				ram_addr = A_TR;
				ram_wd   = fire ? 16'h0000 : tc_inc;
			end
			U_V1: begin
				ram_we   = 1'b1;
				ram_addr = vbase - 16'd1;
				ram_wd   = psr_q;
			end
			U_V2: begin
				ram_we   = 1'b1;
				ram_addr = r_q[6] - 16'd1;
				ram_wd   = pc_q;
			end
			U_V3:    ram_addr = VEC_BASE | {15'h0000, vec_q};
			U_RTI1:  ram_addr = r_q[6];
			U_RTI2:  ram_addr = r_q[6] + 16'd1;
			default: ram_addr = maddr_q;
		endcase
	end

	lc3p_ram #(.WIDTH(16), .DEPTH(MEMORY_WORDS)) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wd),
		.rdata (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_RESET;
			psr_q       <= PSR_RESET;
			sss_q       <= SSP_RESET;
			uss_q       <= USP_RESET;
			tc_q        <= 16'h0000;
			for (int i = 0; i < 8; i++)
				r_q[i] <= 16'h0000;
			r_q[6]      <= SSP_RESET;
			tl_q        <= '0;
			stop_q      <= STOP_NONE;
			mpr_q       <= 16'h0000;
			tmi_q       <= 16'h0000;
			mcr_q       <= MCR_RESET;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// device registers shadowed from every memory write
			if (ram_we) begin
				if (ram_addr == A_MPR)
					mpr_q <= ram_wd;
				if (ram_addr == A_TMI)
					tmi_q <= ram_wd;
				if (ram_addr == A_MCR)
					mcr_q <= ram_wd;
			end
			if (cmd.uop == U_DONE)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (cmd.uop)
				U_CLR:   clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
				U_FETCH: pc_q <= pc_q + 16'd1;
				U_EXEC: begin
					case (opc)
						OPC_BR: begin
							if ((dr & psr_q[2:0]) != 3'b000)
								pc_q <= pc_q + sext9;
						end
						OPC_ADD: begin
							r_q[dr]    <= rs + alu_b;
							psr_q[2:0] <= cc_of(rs + alu_b);
						end
						OPC_AND: begin
							r_q[dr]    <= rs & alu_b;
							psr_q[2:0] <= cc_of(rs & alu_b);
						end
						OPC_NOT: begin
							r_q[dr]    <= ~rs;
							psr_q[2:0] <= cc_of(~rs);
						end
						OPC_LEA: begin
							r_q[dr]    <= pc_q + sext9;
							psr_q[2:0] <= cc_of(pc_q + sext9);
						end
						OPC_JSR: begin
							pc_q   <= ir_q[11] ? (pc_q + sext11) : rs;
							r_q[7] <= pc_q;
						end
						OPC_JMP: begin
							if (ir_q[5:0] == 6'd1) begin
								sss_q     <= r_q[6];
								r_q[6]    <= uss_q;
								pc_q      <= (sr == 3'd6) ? uss_q : rs;
								psr_q[15] <= 1'b0;
							end else if (ir_q[5:0] == 6'd0) begin
								pc_q <= rs;
								if (ret_hit) begin
									tl_q      <= tl_m1;
									psr_q[15] <= tsm_q[top_idx];
								end
							end else begin
								stop_q <= STOP_JMP;
							end
						end
						OPC_TRAP: begin
							if (tl_q >= TL_W'(TRAP_DEPTH)) begin
								stop_q <= STOP_TRAP;
							end else begin
								tl_q      <= tl_q + TL_W'(1);
								r_q[7]    <= pc_q;
								psr_q[15] <= 1'b1;
							end
						end
						OPC_RSV: stop_q <= STOP_RSV;
						default: ;
					endcase
				end
				U_LD_FIN: begin
					r_q[dr]    <= mdata_q;
					psr_q[2:0] <= cc_of(mdata_q);
				end
				U_TRAP_FIN: pc_q <= mdata_q;
				U_W_TMI:    tc_q <= 16'h0000;
				U_T_TICK:   tc_q <= fire ? 16'h0000 : tc_inc;
				U_RTI2:     r_q[6] <= r_q[6] + 16'd1;
				U_RTI3: begin
					sss_q  <= r_q[6] + 16'd1;
					pc_q   <= t_q;
					psr_q  <= ram_rd;
					r_q[6] <= ram_rd[15] ? (r_q[6] + 16'd1) : uss_q;
				end
				U_V1: begin
					if (!psr_q[15])
						uss_q <= r_q[6];
					r_q[6] <= vbase - 16'd1;
				end
				U_V2: r_q[6] <= r_q[6] - 16'd1;
				U_V3: begin
					sss_q     <= r_q[6];
					psr_q[15] <= 1'b1;
				end
				U_V4: pc_q <= ram_rd;
				default: ;
			endcase
		end
	end

	// trap return stack, written before it is read
	always_ff @(posedge clk) begin
		if (cmd.uop == U_EXEC && opc == OPC_TRAP && !(tl_q >= TL_W'(TRAP_DEPTH))) begin
			tsm_q[tl_idx] <= psr_q[15];
			tra_q[tl_idx] <= pc_q;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.uop)
			U_ACCEPT: begin
				addr_in_q   <= s_tdata[15:0];
				data_in_q   <= s_tdata[31:16];
				key_avail_q <= s_tdata[32];
				key_code_q  <= s_tdata[40:33];
				psr0_q      <= psr_q;
				exc_q       <= 1'b0;
				took_q      <= 1'b0;
				dv_q        <= 1'b0;
				dc_q        <= 8'h00;
				irq_q       <= 1'b0;
				peek_q      <= 16'h0000;
			end
			U_PEEK_CAP: peek_q <= ram_rd;
			U_FETCH:    maddr_q <= pc_q;
			U_M_KB1:    mdata_q <= DEV_READY;
			U_M_KB2: begin
				key_avail_q <= 1'b0;
				took_q      <= 1'b1;
			end
			U_M_KB0:  mdata_q <= 16'h0000;
			U_M_DSR:  mdata_q <= DEV_READY;
			U_M_CAP:  mdata_q <= ram_rd;
			U_DECODE: ir_q <= mdata_q;
			U_EXEC: begin
				case (opc)
					OPC_LD, OPC_LDI, OPC_ST, OPC_STI: maddr_q <= pc_q + sext9;
					OPC_LDR, OPC_STR:                 maddr_q <= rs + sext6;
					OPC_TRAP:                         maddr_q <= {8'h00, ir_q[7:0]};
					default: ;
				endcase
			end
			U_IND: maddr_q <= mdata_q;
			U_W_WR: begin
				if (maddr_q == A_DDR) begin
					dv_q <= 1'b1;
					dc_q <= wdata[7:0];
				end
			end
			U_RTI2: t_q <= ram_rd;
			U_FAULT: begin
				exc_q <= 1'b1;
				vec_q <= 1'b0;
			end
			U_T_TICK: begin
				if (fire) begin
					irq_q <= 1'b1;
					vec_q <= 1'b1;
				end
			end
			U_DONE: out_q <= {1'b0, stop_q, running, irq_q, exc_q, took_q, dc_q, dv_q,
				peek_q, psr_q, pc_q};
			default: ;
		endcase
	end

	assign m_tdata  = out_q;
	assign m_tvalid = out_valid_q;
endmodule
